/* rtl/core/mrctm_pkg.sv */
// Shared types and constants for the motor ramp, current and thermal model.
package mrctm_pkg;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes (word address = byte address >> 2)
    localparam logic [2:0] REG_SPEED_LIMIT  = 3'd0;
    localparam logic [2:0] REG_RAMP_STEP    = 3'd1;
    localparam logic [2:0] REG_CURRENT_GAIN = 3'd2;
    localparam logic [2:0] REG_CUR_LIMIT    = 3'd3;
    localparam logic [2:0] REG_EFFICIENCY   = 3'd4;
    localparam logic [2:0] REG_SUPPLY_V     = 3'd5;
    localparam logic [2:0] REG_THERMAL_RES  = 3'd6;
    localparam logic [2:0] REG_AMBIENT      = 3'd7;

    // reset values
    localparam logic [15:0]        RST_SPEED_LIMIT  = 16'd10000;
    localparam logic [15:0]        RST_RAMP_STEP    = 16'd1000;
    localparam logic [23:0]        RST_CURRENT_GAIN = 24'd655;
    localparam logic [15:0]        RST_CUR_LIMIT    = 16'd30000;
    localparam logic [15:0]        RST_EFFICIENCY   = 16'd58982;
    localparam logic [15:0]        RST_SUPPLY_V     = 16'd11100;
    localparam logic [15:0]        RST_THERMAL_RES  = 16'd128;
    localparam logic signed [15:0] RST_AMBIENT      = 16'sd6400;
    localparam logic signed [23:0] RST_TEMP         = 24'sd6400;

    // arithmetic constants
    localparam logic [31:0] UW_PER_W    = 32'd1000000;
    localparam logic [31:0] RECIP_1E6   = 32'd281474976;   // floor(2^48 / 1e6)
    localparam logic [31:0] RECIP_10    = 32'hCCCCCCCD;    // ceil(2^35 / 10)
    localparam logic [16:0] UNITY_Q16   = 17'h10000;
    localparam logic signed [31:0] TEMP_MAX = 32'sd8388607;
    localparam logic signed [31:0] TEMP_MIN = -32'sd8388608;

    typedef struct packed {
        logic [15:0]        speed_limit;
        logic [15:0]        ramp_step;
        logic [23:0]        current_gain;
        logic [15:0]        cur_limit;
        logic [15:0]        efficiency;
        logic [15:0]        supply_voltage;
        logic [15:0]        therm_res;
        logic signed [15:0] ambient_temp;
    } t_cfg;

endpackage

/* rtl/core/mrctm_if.sv */
// Valid/ready channel interfaces for tick requests and tick results.
interface mrctm_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] speed_req;

    modport source (output valid, output speed_req, input ready);
    modport sink   (input valid, input speed_req, output ready);
endinterface

interface mrctm_rsp_if;
    logic               valid;
    logic               ready;
    logic [15:0]        speed_now;
    logic [15:0]        current_draw;
    logic [31:0]        pwr_in;
    logic [31:0]        loss_power;
    logic signed [23:0] temperature;

    modport source (output valid, output speed_now, output current_draw, output pwr_in,
                    output loss_power, output temperature, input ready);
    modport sink   (input valid, input speed_now, input current_draw, input pwr_in,
                    input loss_power, input temperature, output ready);
endinterface

/* rtl/core/mrctm_regs.sv */
// APB configuration register file.
module mrctm_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrctm_pkg::APB_AW-1:0] paddr,
    input  logic [mrctm_pkg::APB_DW-1:0] pwdata,
    output logic [mrctm_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output mrctm_pkg::t_cfg              o_cfg
);
    import mrctm_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit    <= RST_SPEED_LIMIT;
            r_cfg.ramp_step      <= RST_RAMP_STEP;
            r_cfg.current_gain   <= RST_CURRENT_GAIN;
            r_cfg.cur_limit      <= RST_CUR_LIMIT;
            r_cfg.efficiency     <= RST_EFFICIENCY;
            r_cfg.supply_voltage <= RST_SUPPLY_V;
            r_cfg.therm_res      <= RST_THERMAL_RES;
            r_cfg.ambient_temp   <= RST_AMBIENT;
        end else if (wr_en) begin
            case (idx)
                REG_SPEED_LIMIT:  r_cfg.speed_limit    <= pwdata[15:0];
                REG_RAMP_STEP:    r_cfg.ramp_step      <= pwdata[15:0];
                REG_CURRENT_GAIN: r_cfg.current_gain   <= pwdata[23:0];
                REG_CUR_LIMIT:    r_cfg.cur_limit      <= pwdata[15:0];
                REG_EFFICIENCY:   r_cfg.efficiency     <= pwdata[15:0];
                REG_SUPPLY_V:     r_cfg.supply_voltage <= pwdata[15:0];
                REG_THERMAL_RES:  r_cfg.therm_res      <= pwdata[15:0];
                REG_AMBIENT:      r_cfg.ambient_temp   <= $signed(pwdata[15:0]);
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SPEED_LIMIT:  prdata = {16'd0, r_cfg.speed_limit};
            REG_RAMP_STEP:    prdata = {16'd0, r_cfg.ramp_step};
            REG_CURRENT_GAIN: prdata = {8'd0, r_cfg.current_gain};
            REG_CUR_LIMIT:    prdata = {16'd0, r_cfg.cur_limit};
            REG_EFFICIENCY:   prdata = {16'd0, r_cfg.efficiency};
            REG_SUPPLY_V:     prdata = {16'd0, r_cfg.supply_voltage};
            REG_THERMAL_RES:  prdata = {16'd0, r_cfg.therm_res};
            REG_AMBIENT:      prdata = {{16{r_cfg.ambient_temp[15]}}, r_cfg.ambient_temp};
            default:          prdata = '0;
        endcase
    end

endmodule

/* rtl/core/mrctm_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
module mrctm_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {32'd0, i_a} * {32'd0, i_b};
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/motor_ramp_current_thermal_model.sv */
// Top level of the motor ramp, current and thermal model.
//
// Usage:
//   i_req carries one simulated one-second tick (speed_req, rpm). Each
//   accepted transaction yields exactly one transaction on o_rsp with the
//   ramped speed, current, input and loss power, and the new temperature.
//   Configuration goes through the APB port (8 registers at byte address 4*i);
//   write it only while the block is idle.
// Sequencing:
//   One tick walks a 12-state sequencer around a single shared 32x32
//   multiplier (seven products: current, power, loss, thermal rise,
//   reciprocal divide by 1e6, back-multiply for the remainder, divide by 10).
//   The result is registered in S_DONE once the output is free; the next
//   request is taken only after the sequencer has returned to S_IDLE.
// Reset (i_rst_n, synchronous, active low):
//   registers return to their defaults, speed to 0, temperature to 25 C
//   (6400), both channels empty.
// Stall:
//   o_rsp holds its transaction until taken. The next tick is accepted and
//   computed meanwhile; it waits in its last state until the output frees.
module motor_ramp_current_thermal_model (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mrctm_req_if.sink                    i_req,
    mrctm_rsp_if.source                  o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrctm_pkg::APB_AW-1:0] paddr,
    input  logic [mrctm_pkg::APB_DW-1:0] pwdata,
    output logic [mrctm_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import mrctm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CUR, S_CLAMP, S_PWR, S_LOSS, S_RISE,
        S_RECIP, S_BACK, S_CORR, S_DIFF, S_DIV, S_DONE
    } t_state;

    t_cfg cfg;

    mrctm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer and datapath registers
    t_state             r_state;
    logic [15:0]        r_d;        // clamped desired speed
    logic [15:0]        r_speed;
    logic signed [23:0] r_temp;
    logic [15:0]        r_cur;
    logic [31:0]        r_pwr;
    logic [31:0]        r_loss;
    logic [47:0]        r_x;        // loss * thermal resistance
    logic [28:0]        r_q;        // thermal rise quotient
    logic signed [31:0] r_diff;     // target - temperature

    // output register
    logic               r_ovalid;
    logic [15:0]        r_o_speed;
    logic [15:0]        r_o_cur;
    logic [31:0]        r_o_pwr;
    logic [31:0]        r_o_loss;
    logic signed [23:0] r_o_temp;

    // shared multiplier
    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    mrctm_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    logic [16:0] loss_factor;
    logic [31:0] diff_abs;

    assign loss_factor = UNITY_Q16 - {1'b0, cfg.efficiency};
    assign diff_abs    = r_diff[31] ? 32'(-r_diff) : 32'(r_diff);

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_CUR: begin
                mul_a = {16'd0, r_d};
                mul_b = {8'd0, cfg.current_gain};
            end
            S_PWR: begin
                mul_a = {16'd0, cfg.supply_voltage};
                mul_b = {16'd0, r_cur};
            end
            S_LOSS: begin
                mul_a = prod[31:0];
                mul_b = {15'd0, loss_factor};
            end
            S_RISE: begin
                mul_a = prod[47:16];
                mul_b = {16'd0, cfg.therm_res};
            end
            S_RECIP: begin
                // quotient estimate from x >> 16, low by at most one
                mul_a = prod[47:16];
                mul_b = RECIP_1E6;
            end
            S_BACK: begin
                mul_a = {3'd0, prod[60:32]};
                mul_b = UW_PER_W;
            end
            S_DIV: begin
                mul_a = diff_abs;
                mul_b = RECIP_10;
            end
            default: mul_en = 1'b0;
        endcase
    end

    // speed ramp toward the clamped target
    logic [15:0] n_speed;
    logic [16:0] speed_up;
    logic [15:0] speed_gap;

    assign speed_up  = {1'b0, r_speed} + {1'b0, cfg.ramp_step};
    assign speed_gap = r_speed - r_d;

    always_comb begin
        n_speed = r_speed;
        if (r_speed < r_d) begin
            n_speed = (speed_up > {1'b0, r_d}) ? r_d : speed_up[15:0];
        end else if (r_speed > r_d) begin
            n_speed = (speed_gap > cfg.ramp_step) ? r_speed - cfg.ramp_step : r_d;
        end
    end

    // current clamp
    logic [15:0] n_cur;
    assign n_cur = (prod[39:16] > {8'd0, cfg.cur_limit}) ? cfg.cur_limit : prod[31:16];

    // quotient correction
    logic [47:0] rem;
    assign rem = r_x - prod[47:0];

    // temperature step
    logic [28:0]        quo;
    logic signed [31:0] step;
    logic signed [31:0] t_sum;
    logic signed [23:0] n_temp;

    assign quo   = prod[63:35];
    assign step  = r_diff[31] ? -$signed({3'd0, quo}) : $signed({3'd0, quo});
    assign t_sum = 32'(r_temp) + step;

    always_comb begin
        if (t_sum > TEMP_MAX) begin
            n_temp = TEMP_MAX[23:0];
        end else if (t_sum < TEMP_MIN) begin
            n_temp = TEMP_MIN[23:0];
        end else begin
            n_temp = t_sum[23:0];
        end
    end

    logic out_free;
    assign out_free = !r_ovalid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_speed  <= '0;
            r_temp   <= RST_TEMP;
        end else begin
            // a finished tick refills the output in the cycle the old one leaves
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_d     <= (i_req.speed_req > cfg.speed_limit) ?
                                   cfg.speed_limit : i_req.speed_req;
                        r_state <= S_CUR;
                    end
                end
                S_CUR: begin
                    r_speed <= n_speed;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_cur   <= n_cur;
                    r_state <= S_PWR;
                end
                S_PWR:   r_state <= S_LOSS;
                S_LOSS: begin
                    r_pwr   <= prod[31:0];
                    r_state <= S_RISE;
                end
                S_RISE: begin
                    r_loss  <= prod[47:16];
                    r_state <= S_RECIP;
                end
                S_RECIP: begin
                    r_x     <= prod[47:0];
                    r_state <= S_BACK;
                end
                S_BACK: begin
                    r_q     <= prod[60:32];
                    r_state <= S_CORR;
                end
                S_CORR: begin
                    if (rem >= {16'd0, UW_PER_W}) begin
                        r_q <= r_q + 29'd1;
                    end
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_diff  <= 32'(cfg.ambient_temp) + $signed({3'd0, r_q}) - 32'(r_temp);
                    r_state <= S_DIV;
                end
                S_DIV:   r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_temp    <= n_temp;
                        r_o_speed <= r_speed;
                        r_o_cur   <= r_cur;
                        r_o_pwr   <= r_pwr;
                        r_o_loss  <= r_loss;
                        r_o_temp  <= n_temp;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.speed_now    = r_o_speed;
    assign o_rsp.current_draw = r_o_cur;
    assign o_rsp.pwr_in       = r_o_pwr;
    assign o_rsp.loss_power   = r_o_loss;
    assign o_rsp.temperature  = r_o_temp;

`ifndef SYNTHESIS
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_CUR))
        else $error("accepted tick did not start the sequence");

    a_speed_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_d <= cfg.speed_limit))
        else $error("clamped speed above the speed limit");

    a_cur_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PWR) |-> (r_cur <= cfg.cur_limit))
        else $error("current above the current limit");

    a_loss_le_pwr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RECIP) |-> (r_loss <= r_pwr))
        else $error("loss power exceeds input power");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_rsp.ready) |=> (r_ovalid && $stable(r_o_temp)))
        else $error("pending result lost or changed");
`endif

endmodule
